FILE: design/cic_pkg.sv
// cic_pkg: shared types, constants and the byte-wide CRC-32 step for the
// credential image checker. No dependencies.
package cic_pkg;

	localparam int unsigned HEADER_BYTES = 8;
	localparam int unsigned CHECKSUM_BYTES = 4;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;
	localparam logic [31:0] IMAGE_MAGIC = 32'h57494649;
	localparam logic [15:0] IMAGE_VERSION = 16'd1;

	localparam logic [2:0] REQ_RESET = 3'd6;

	// result status codes
	localparam logic [2:0] ST_OK_CRC = 3'd0;
	localparam logic [2:0] ST_OK_XOR = 3'd1;
	localparam logic [2:0] ST_NONE_REQ = 3'd2;
	localparam logic [2:0] ST_SHORT = 3'd3;
	localparam logic [2:0] ST_MAGIC = 3'd4;
	localparam logic [2:0] ST_VERSION = 3'd5;
	localparam logic [2:0] ST_COUNT = 3'd6;
	localparam logic [2:0] ST_CHECKSUM = 3'd7;

	// everything the result decode needs, captured on the last byte
	typedef struct packed {
		logic        short_img;
		logic        magic_ok;
		logic        version_ok;
		logic [15:0] count;
		logic [31:0] crc;
		logic [31:0] xor_sum;
		logic [31:0] checksum;
	} snap_t;

	// reflected CRC-32, one byte, unrolled over its eight bits
	function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
		logic [31:0] c;
		c = acc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

FILE: design/cic_accum.sv
// cic_accum: per-byte stream state (position, CRC, lane XOR, header fields,
// stored checksum) and the snapshot register loaded on the last byte.
// Depends on cic_pkg.
module cic_accum import cic_pkg::*; #(
	parameter int unsigned ENTRY_LIMIT = 6,
	parameter int unsigned ENTRY_BYTES = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_fire,
	input  logic [7:0]  image_byte,
	input  logic        last_byte,
	input  logic        snap_pop,
	output snap_t       snap_s1,
	output logic        snap_valid_s1
);

	localparam int unsigned DATA_BYTES = HEADER_BYTES + ENTRY_LIMIT * ENTRY_BYTES;
	localparam int unsigned IMAGE_BYTES = DATA_BYTES + CHECKSUM_BYTES;
	localparam int unsigned POS_W = $clog2(IMAGE_BYTES + 1);

	logic [POS_W-1:0] pos_q, pos_d;
	logic [31:0]      crc_q, crc_d;
	logic [31:0]      xor_q, xor_d;
	logic [31:0]      magic_q, magic_d;
	logic [15:0]      version_q, version_d;
	logic [15:0]      count_q, count_d;
	logic [31:0]      chk_q, chk_d;
	logic [1:0]       chk_idx;
	logic             in_data, in_chk;

	assign in_data = pos_q < POS_W'(DATA_BYTES);
	assign in_chk  = !in_data && (pos_q < POS_W'(IMAGE_BYTES));
	assign chk_idx = 2'(pos_q - POS_W'(DATA_BYTES));

	always_comb begin
		pos_d     = pos_q;
		crc_d     = crc_q;
		xor_d     = xor_q;
		magic_d   = magic_q;
		version_d = version_q;
		count_d   = count_q;
		chk_d     = chk_q;
		if (in_data) begin
			crc_d = crc_byte(crc_q, image_byte);
			xor_d[{pos_q[1:0], 3'b000} +: 8] = xor_q[{pos_q[1:0], 3'b000} +: 8] ^ image_byte;
			if (pos_q < POS_W'(4)) begin
				magic_d[{pos_q[1:0], 3'b000} +: 8] = image_byte;
			end else if (pos_q < POS_W'(6)) begin
				version_d[{pos_q[0], 3'b000} +: 8] = image_byte;
			end else if (pos_q < POS_W'(8)) begin
				count_d[{pos_q[0], 3'b000} +: 8] = image_byte;
			end
		end else if (in_chk) begin
			chk_d[{chk_idx, 3'b000} +: 8] = image_byte;
		end
		if (pos_q < POS_W'(IMAGE_BYTES)) begin
			pos_d = pos_q + POS_W'(1);
		end
	end

	// stream state: cleared after the last byte of each image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= ALL_ONES;
			xor_q     <= '0;
			magic_q   <= '0;
			version_q <= '0;
			count_q   <= '0;
			chk_q     <= '0;
		end else if (in_fire) begin
			if (last_byte) begin
				pos_q     <= '0;
				crc_q     <= ALL_ONES;
				xor_q     <= '0;
				magic_q   <= '0;
				version_q <= '0;
				count_q   <= '0;
				chk_q     <= '0;
			end else begin
				pos_q     <= pos_d;
				crc_q     <= crc_d;
				xor_q     <= xor_d;
				magic_q   <= magic_d;
				version_q <= version_d;
				count_q   <= count_d;
				chk_q     <= chk_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (in_fire && last_byte) begin
			snap_valid_s1 <= 1'b1;
		end else if (snap_pop) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && last_byte) begin
			snap_s1.short_img  <= pos_d < POS_W'(IMAGE_BYTES);
			snap_s1.magic_ok   <= magic_d == IMAGE_MAGIC;
			snap_s1.version_ok <= version_d == IMAGE_VERSION;
			snap_s1.count      <= count_d;
			snap_s1.crc        <= crc_d ^ ALL_ONES;
			snap_s1.xor_sum    <= xor_d;
			snap_s1.checksum   <= chk_d;
		end
	end

endmodule

FILE: design/cic_judge.sv
// cic_judge: ordered checks on a captured image and the result output register.
// Depends on cic_pkg.
module cic_judge import cic_pkg::*; #(
	parameter int unsigned ENTRY_LIMIT = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  snap_t       snap_s1,
	input  logic        snap_valid_s1,
	input  logic [2:0]  req_q,
	output logic        snap_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [2:0]  accepted_count,
	output logic [31:0] computed_crc
);

	logic [2:0] status_d;
	logic [2:0] accepted_d;
	logic       out_valid_q;

	assign snap_pop = snap_valid_s1 && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		if (req_q == 3'd0) begin
			status_d = ST_NONE_REQ;
		end else if (snap_s1.short_img) begin
			status_d = ST_SHORT;
		end else if (!snap_s1.magic_ok) begin
			status_d = ST_MAGIC;
		end else if (!snap_s1.version_ok) begin
			status_d = ST_VERSION;
		end else if (snap_s1.count > 16'(ENTRY_LIMIT)) begin
			status_d = ST_COUNT;
		end else if (snap_s1.checksum == snap_s1.crc) begin
			status_d = ST_OK_CRC;
		end else if (snap_s1.checksum == snap_s1.xor_sum) begin
			status_d = ST_OK_XOR;
		end else begin
			status_d = ST_CHECKSUM;
		end
		accepted_d = 3'd0;
		if (status_d == ST_OK_CRC || status_d == ST_OK_XOR) begin
			accepted_d = (snap_s1.count < {13'd0, req_q}) ? snap_s1.count[2:0] : req_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (snap_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_pop) begin
			status         <= status_d;
			accepted_count <= accepted_d;
			computed_crc   <= snap_s1.crc;
		end
	end

endmodule

FILE: design/credential_image_checker.sv
// credential_image_checker: top level; config register, input handshake,
// accumulate stage and result stage. Depends on cic_pkg, cic_accum, cic_judge.
//
// Checks a stored credential image streamed one byte per request, little-endian:
// 4-byte magic, 2-byte version, 2-byte entry count, an entry area of
// ENTRY_LIMIT * ENTRY_BYTES bytes and a 4-byte stored checksum. Over the header
// and entry area it keeps a reflected CRC-32 and a lane-wise XOR-32; bytes past
// the image are ignored. The request flagged last_byte produces exactly one
// result (status, accepted_count, computed_crc); the stream state then clears
// for the next image while requested_entries keeps its value. Throughput is one
// byte per clock while in_ready is high: the byte-wide CRC step and field capture
// are combinational into the accumulator registers. A result goes from its last
// byte to the snapshot register, then through the result decode to the output
// register. in_ready drops only while a finished result is held in the snapshot
// stage and the output register cannot take it. requested_entries is written
// through the cfg channel (always ready) and must change only while idle.
module credential_image_checker import cic_pkg::*; #(
	parameter int unsigned ENTRY_LIMIT = 6,
	parameter int unsigned ENTRY_BYTES = 100
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  requested_entries,
	// byte request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  image_byte,
	input  logic        last_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [2:0]  accepted_count,
	output logic [31:0] computed_crc
);

	logic [2:0] req_q;
	logic       in_fire;
	logic       snap_pop;
	logic       snap_valid_s1;
	snap_t      snap_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= REQ_RESET;
		end else if (cfg_valid && cfg_ready) begin
			req_q <= requested_entries;
		end
	end

	// the snapshot slot is free or drains this cycle
	assign in_ready = !snap_valid_s1 || snap_pop;
	assign in_fire  = in_valid && in_ready;

	cic_accum #(
		.ENTRY_LIMIT (ENTRY_LIMIT),
		.ENTRY_BYTES (ENTRY_BYTES)
	) u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_fire       (in_fire),
		.image_byte    (image_byte),
		.last_byte     (last_byte),
		.snap_pop      (snap_pop),
		.snap_s1       (snap_s1),
		.snap_valid_s1 (snap_valid_s1)
	);

	cic_judge #(
		.ENTRY_LIMIT (ENTRY_LIMIT)
	) u_judge (
		.clk            (clk),
		.arst_n         (arst_n),
		.snap_s1        (snap_s1),
		.snap_valid_s1  (snap_valid_s1),
		.req_q          (req_q),
		.snap_pop       (snap_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.accepted_count (accepted_count),
		.computed_crc   (computed_crc)
	);

endmodule
